/* src/hlmd_pkg.sv */
package hlmd_pkg;

   localparam int WORD_W  = 32;
   localparam int DWORD_W = 2 * WORD_W;
   localparam int CNT_W   = $clog2(WORD_W);
   localparam int OP_W    = 4;
   localparam int REQ_W   = 2 * WORD_W;
   // read_value, writes_destination, divide_by_zero, hi_now, lo_now, padded to bytes
   localparam int RSP_USED_W = 3 * WORD_W + 2;
   localparam int RSP_W      = ((RSP_USED_W + 7) / 8) * 8;

   typedef enum logic [OP_W-1:0] {
      OP_MULT  = 4'd0,
      OP_MULTU = 4'd1,
      OP_DIV   = 4'd2,
      OP_DIVU  = 4'd3,
      OP_MADD  = 4'd4,
      OP_MADDU = 4'd5,
      OP_MSUB  = 4'd6,
      OP_MSUBU = 4'd7,
      OP_MUL   = 4'd8,
      OP_MFHI  = 4'd9,
      OP_MFLO  = 4'd10,
      OP_MTHI  = 4'd11,
      OP_MTLO  = 4'd12
   } op_type;

   // Command from the sequencer to the shift-add/subtract unit.
   typedef struct packed {
      logic start;
      logic is_div;
   } iter_ctl_type;

   // Status back from the shift-add/subtract unit.
   typedef struct packed {
      logic busy;
      logic done;
   } iter_sts_type;

endpackage

/* src/hlmd_iter_unit.sv */
module hlmd_iter_unit
   import hlmd_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  iter_ctl_type         ctl,
   input  logic [WORD_W-1:0]    a_mag,
   input  logic [WORD_W-1:0]    b_mag,
   output iter_sts_type         sts,
   output logic [DWORD_W-1:0]   result
);

   // One 33-bit adder serves both radix-2 multiply (shift right, add) and
   // restoring divide (shift left, trial subtract). The accumulator holds
   // partial product and multiplier, or remainder and quotient.
   logic [DWORD_W-1:0] acc_ff, acc_in;
   logic [WORD_W-1:0]  opnd_ff;
   logic               is_div_ff;
   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   logic [CNT_W-1:0]   count_ff, count_in;

   logic [WORD_W:0]    lhs;
   logic [WORD_W:0]    rhs;
   logic [WORD_W+1:0]  sum;

   always_comb begin
      lhs = is_div_ff ? {1'b0, acc_ff[DWORD_W-2:WORD_W-1]}
                      : {1'b0, acc_ff[DWORD_W-1:WORD_W]};
      rhs = {1'b0, opnd_ff};
      sum = {1'b0, lhs} + {1'b0, (is_div_ff ? ~rhs : rhs)} + {{(WORD_W+1){1'b0}}, is_div_ff};
   end

   always_comb begin
      acc_in   = acc_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      count_in = count_ff;
      if (ctl.start) begin
         acc_in   = {{WORD_W{1'b0}}, a_mag};
         busy_in  = 1'b1;
         count_in = CNT_W'(WORD_W - 1);
      end else if (busy_ff) begin
         if (is_div_ff) begin
            if (sum[WORD_W+1]) begin
               acc_in = {sum[WORD_W-1:0], acc_ff[WORD_W-2:0], 1'b1};
            end else begin
               acc_in = {acc_ff[DWORD_W-2:0], 1'b0};
            end
         end else begin
            if (acc_ff[0]) begin
               acc_in = {sum[WORD_W:0], acc_ff[WORD_W-1:1]};
            end else begin
               acc_in = {1'b0, acc_ff[DWORD_W-1:1]};
            end
         end
         count_in = count_ff - 1'b1;
         if (count_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff   <= acc_in;
      count_ff <= count_in;
      if (ctl.start) begin
         opnd_ff   <= b_mag;
         is_div_ff <= ctl.is_div;
      end
   end

   assign sts.busy = busy_ff;
   assign sts.done = done_ff;
   assign result   = acc_ff;

endmodule

/* src/hi_lo_multiply_divide_unit.sv */
// Multiply, divide and multiply-accumulate pass from acceptance to the result beat
// through 32 shift-add/subtract iterations in the shared unit, one sign fix-up
// and the write-back. Moves, mul-free operations and divides by zero go straight to it.
// A new beat is taken only once the sequencer is back in idle after the previous result
// is registered, so no beat is accepted while another one is still in flight.
// Synchronous active-high reset clears HI, LO, the sequencer and the result valid.
module hi_lo_multiply_divide_unit
   import hlmd_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   // [31:0] operand_a, [63:32] operand_b
   input  logic [REQ_W-1:0]  req_tdata,
   // [3:0] operation
   input  logic [OP_W-1:0]   req_tuser,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   // [31:0] read_value, [32] writes_destination, [33] divide_by_zero,
   // [65:34] hi_now, [97:66] lo_now, [103:98] zero
   output logic [RSP_W-1:0]  rsp_tdata
);

   // Four states: Idle takes a request beat; Run waits for the shared iterative unit;
   // Fix applies the signs to the magnitude result; Write updates HI and LO and loads
   // the result register. Beats that skip the unit go from Idle straight to Write.
   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_RUN   = 4'b0010,
      ST_FIX   = 4'b0100,
      ST_WRITE = 4'b1000
   } state_type;

   state_type state_ff, state_in;

   op_type              op_ff;
   logic [WORD_W-1:0]   a_ff;
   logic                neg_lo_ff;   // product or quotient is negative
   logic                neg_hi_ff;   // remainder takes the sign of the dividend
   logic                dbz_ff;
   logic [DWORD_W-1:0]  res_ff, res_in;
   logic [WORD_W-1:0]   hi_ff, hi_in, lo_ff, lo_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [RSP_W-1:0]    rsp_data_ff, rsp_data_in;

   // Decode of the incoming beat.
   op_type              req_op;
   logic [WORD_W-1:0]   req_a, req_b;
   logic                req_signed, req_mul_class, req_div_class, req_b_zero;
   logic                neg_a, neg_b, go_run, accept;
   logic [WORD_W-1:0]   a_mag, b_mag;

   iter_ctl_type        iter_ctl;
   iter_sts_type        iter_sts;
   logic [DWORD_W-1:0]  iter_result;

   logic                write_fire;
   logic [WORD_W-1:0]   read_value;
   logic                writes_dest;

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      req_op = op_type'(req_tuser);
      req_a  = req_tdata[WORD_W-1:0];
      req_b  = req_tdata[REQ_W-1:WORD_W];
      req_signed = (req_op == OP_MULT) || (req_op == OP_DIV) || (req_op == OP_MADD) ||
                   (req_op == OP_MSUB) || (req_op == OP_MUL);
      req_div_class = (req_op == OP_DIV) || (req_op == OP_DIVU);
      req_mul_class = (req_op == OP_MULT) || (req_op == OP_MULTU) ||
                      (req_op == OP_MADD) || (req_op == OP_MADDU) ||
                      (req_op == OP_MSUB) || (req_op == OP_MSUBU) || (req_op == OP_MUL);
      req_b_zero = (req_b == '0);
      neg_a = req_signed && req_a[WORD_W-1];
      neg_b = req_signed && req_b[WORD_W-1];
      // The most negative word maps onto itself, which is its correct magnitude
      // when read as unsigned.
      a_mag = neg_a ? (WORD_W'(0) - req_a) : req_a;
      b_mag = neg_b ? (WORD_W'(0) - req_b) : req_b;
      go_run = req_mul_class || (req_div_class && !req_b_zero);
   end

   assign iter_ctl.start  = accept && go_run;
   assign iter_ctl.is_div = req_div_class;

   hlmd_iter_unit u_iter (
      .clock  (clock),
      .reset  (reset),
      .ctl    (iter_ctl),
      .a_mag  (a_mag),
      .b_mag  (b_mag),
      .sts    (iter_sts),
      .result (iter_result)
   );

   // A result beat may only be loaded once the previous one has gone.
   assign write_fire = (state_ff == ST_WRITE) && (!rsp_valid_ff || rsp_tready);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = go_run ? ST_RUN : ST_WRITE;
            end
         end
         ST_RUN: begin
            if (iter_sts.done) begin
               state_in = ST_FIX;
            end
         end
         ST_FIX: begin
            state_in = ST_WRITE;
         end
         ST_WRITE: begin
            if (write_fire) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Sign fix-up: the divide result carries the remainder in the upper word and
   // the quotient in the lower word, each negated on its own.
   always_comb begin
      res_in = res_ff;
      if (state_ff == ST_FIX) begin
         if ((op_ff == OP_DIV) || (op_ff == OP_DIVU)) begin
            res_in[DWORD_W-1:WORD_W] = neg_hi_ff ?
               (WORD_W'(0) - iter_result[DWORD_W-1:WORD_W]) : iter_result[DWORD_W-1:WORD_W];
            res_in[WORD_W-1:0] = neg_lo_ff ?
               (WORD_W'(0) - iter_result[WORD_W-1:0]) : iter_result[WORD_W-1:0];
         end else begin
            res_in = neg_lo_ff ? (DWORD_W'(0) - iter_result) : iter_result;
         end
      end
   end

   // Write-back of HI and LO and the value for the general register.
   always_comb begin
      logic [DWORD_W-1:0] hilo;
      logic [DWORD_W-1:0] hilo_new;
      hilo        = {hi_ff, lo_ff};
      hilo_new    = hilo;
      read_value  = '0;
      writes_dest = 1'b0;
      unique case (op_ff)
         OP_MULT, OP_MULTU: begin
            hilo_new = res_ff;
         end
         OP_DIV, OP_DIVU: begin
            if (!dbz_ff) begin
               hilo_new = res_ff;
            end
         end
         OP_MADD, OP_MADDU: begin
            hilo_new = hilo + res_ff;
         end
         OP_MSUB, OP_MSUBU: begin
            hilo_new = hilo - res_ff;
         end
         OP_MUL: begin
            read_value  = res_ff[WORD_W-1:0];
            writes_dest = 1'b1;
            hilo_new    = '0;
         end
         OP_MFHI: begin
            read_value  = hi_ff;
            writes_dest = 1'b1;
         end
         OP_MFLO: begin
            read_value  = lo_ff;
            writes_dest = 1'b1;
         end
         OP_MTHI: begin
            hilo_new[DWORD_W-1:WORD_W] = a_ff;
         end
         OP_MTLO: begin
            hilo_new[WORD_W-1:0] = a_ff;
         end
         default: begin
            hilo_new = hilo;
         end
      endcase
      hi_in = hilo_new[DWORD_W-1:WORD_W];
      lo_in = hilo_new[WORD_W-1:0];
      rsp_data_in = {{(RSP_W - RSP_USED_W){1'b0}}, lo_in, hi_in, dbz_ff, writes_dest,
                     read_value};
   end

   assign rsp_valid_in = write_fire || (rsp_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         hi_ff        <= '0;
         lo_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (write_fire) begin
            hi_ff <= hi_in;
            lo_ff <= lo_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      res_ff <= res_in;
      if (accept) begin
         op_ff     <= req_op;
         a_ff      <= req_a;
         neg_lo_ff <= neg_a ^ neg_b;
         neg_hi_ff <= neg_a;
         dbz_ff    <= req_div_class && req_b_zero;
      end
      if (write_fire) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // The shared unit only runs while the sequencer is waiting for it.
   a_busy_in_run: assert property (@(posedge clock) disable iff (reset)
      iter_sts.busy |-> (state_ff == ST_RUN))
      else $error("iterative unit busy outside the run state");

   a_done_in_run: assert property (@(posedge clock) disable iff (reset)
      iter_sts.done |-> (state_ff == ST_RUN))
      else $error("iterative unit finished outside the run state");

   // An accepted beat always leaves the idle state.
   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff != ST_IDLE))
      else $error("request beat accepted but sequencer stayed idle");

   // A divide by zero must leave HI and LO untouched.
   a_dbz_keeps_hilo: assert property (@(posedge clock) disable iff (reset)
      (write_fire && dbz_ff) |=> ($stable(hi_ff) && $stable(lo_ff)))
      else $error("divide by zero changed HI or LO");

endmodule
